// ===== sv/oce_pkg.sv =====
// Shared types and constants for the octahedral cell key encoder.
// No dependencies; oce_if, oce_cell, the top level and the testbench use this package.
package oce_pkg;

	// Field widths
	localparam int POS_W = 32;
	localparam int NRM_W = 16;
	localparam int LVL_W = 8;
	localparam int CODE_W = 16;
	localparam int CFG_W = 32;

	// Octahedral bin division: 8-bit quotient, 18-bit divisor 2*L1
	localparam int BIN_QW = 8;
	localparam int BIN_RW = 18;
	localparam int BIN_DVD_W = BIN_RW + BIN_QW;
	localparam int NUM_BIN_LANES = 2;
	localparam int NUM_AXES = 3;

	// Short normal limit in raw Q2.28 units, reset cell edge (1.0 in Q16.16)
	localparam logic [31:0] SHORT_LIMIT = 32'd2684;
	localparam logic [CFG_W-1:0] CELL_SIZE_RST = 32'd65536;

	// Sideband that rides along the divider chain
	typedef struct packed {
		logic [NUM_AXES-1:0] neg;
		logic                zero;
		logic [LVL_W-1:0]    level;
	} oce_side_t;

endpackage

// ===== sv/oce_if.sv =====
// Valid/ready channel interfaces for the octahedral cell key encoder.
// Depends on oce_pkg for field widths.
interface oce_in_if;
	logic                            valid;
	logic                            ready;
	logic signed [oce_pkg::POS_W-1:0] pos_x;
	logic signed [oce_pkg::POS_W-1:0] pos_y;
	logic signed [oce_pkg::POS_W-1:0] pos_z;
	logic signed [oce_pkg::NRM_W-1:0] normal_x;
	logic signed [oce_pkg::NRM_W-1:0] normal_y;
	logic signed [oce_pkg::NRM_W-1:0] normal_z;
	logic [oce_pkg::LVL_W-1:0]        level;

	modport source (output valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, level,
		input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, level,
		output ready);
endinterface

interface oce_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [oce_pkg::POS_W-1:0] cell_x;
	logic signed [oce_pkg::POS_W-1:0] cell_y;
	logic signed [oce_pkg::POS_W-1:0] cell_z;
	logic [oce_pkg::CODE_W-1:0]       normal_code;
	logic [oce_pkg::LVL_W-1:0]        level_out;

	modport source (output valid, cell_x, cell_y, cell_z, normal_code, level_out,
		input ready);
	modport sink (input valid, cell_x, cell_y, cell_z, normal_code, level_out,
		output ready);
endinterface

interface oce_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [oce_pkg::CFG_W-1:0] cell_size;

	modport source (output valid, cell_size, input ready);
	modport sink (input valid, cell_size, output ready);
endinterface

// ===== sv/oce_div_step.sv =====
// One restoring division step: shift in one dividend bit, subtract if it fits.
// No package dependency.
module oce_div_step #(
	parameter int RW = 18,
	parameter int NB = 8
) (
	input  logic [RW-1:0] rem_i,
	input  logic [NB-1:0] acc_i,
	input  logic [RW-1:0] den_i,
	output logic [RW-1:0] rem_o,
	output logic [NB-1:0] acc_o
);
	logic [RW:0] trial;
	logic [RW:0] diff;
	logic        fits;

	// Trial remainder with the next dividend bit, compare against the divisor
	assign trial = {rem_i, acc_i[NB-1]};
	assign fits  = trial >= {1'b0, den_i};
	assign diff  = trial - {1'b0, den_i};
	assign rem_o = fits ? diff[RW-1:0] : trial[RW-1:0];
	assign acc_o = {acc_i[NB-2:0], fits};
endmodule

// ===== sv/oce_cell.sv =====
// One cell of the divider chain: one quotient bit for each position axis and,
// when enabled, for each octahedral bin. Depends on oce_pkg and oce_div_step.
module oce_cell #(
	parameter int DW = 52,
	parameter bit DO_BIN = 1'b1
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            en_next,
	output logic                                            en,
	input  logic                                            v_in,
	output logic                                            v_q,
	input  logic [DW-1:0]                                   den_in,
	input  logic [oce_pkg::NUM_AXES-1:0][DW-1:0]            rem_in,
	input  logic [oce_pkg::NUM_AXES-1:0][oce_pkg::POS_W-1:0] acc_in,
	input  logic [oce_pkg::BIN_RW-1:0]                      bden_in,
	input  logic [oce_pkg::NUM_BIN_LANES-1:0][oce_pkg::BIN_RW-1:0] brem_in,
	input  logic [oce_pkg::NUM_BIN_LANES-1:0][oce_pkg::BIN_QW-1:0] bacc_in,
	input  oce_pkg::oce_side_t                              side_in,
	output logic [DW-1:0]                                   den_q,
	output logic [oce_pkg::NUM_AXES-1:0][DW-1:0]            rem_q,
	output logic [oce_pkg::NUM_AXES-1:0][oce_pkg::POS_W-1:0] acc_q,
	output logic [oce_pkg::BIN_RW-1:0]                      bden_q,
	output logic [oce_pkg::NUM_BIN_LANES-1:0][oce_pkg::BIN_RW-1:0] brem_q,
	output logic [oce_pkg::NUM_BIN_LANES-1:0][oce_pkg::BIN_QW-1:0] bacc_q,
	output oce_pkg::oce_side_t                              side_q
);
	import oce_pkg::*;

	logic [NUM_AXES-1:0][DW-1:0]           rem_n;
	logic [NUM_AXES-1:0][POS_W-1:0]        acc_n;
	logic [NUM_BIN_LANES-1:0][BIN_RW-1:0]  brem_n;
	logic [NUM_BIN_LANES-1:0][BIN_QW-1:0]  bacc_n;

	// Advance when empty or when the next cell advances
	assign en = !v_q || en_next;

	// Position quotient bits
	for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
		oce_div_step #(.RW(DW), .NB(POS_W)) u_step (
			.rem_i(rem_in[a]), .acc_i(acc_in[a]), .den_i(den_in),
			.rem_o(rem_n[a]), .acc_o(acc_n[a])
		);
	end

	// Bin quotient bits, or hold the finished bins
	for (genvar b = 0; b < NUM_BIN_LANES; b++) begin : g_bin
		if (DO_BIN) begin : g_step
			oce_div_step #(.RW(BIN_RW), .NB(BIN_QW)) u_step (
				.rem_i(brem_in[b]), .acc_i(bacc_in[b]), .den_i(bden_in),
				.rem_o(brem_n[b]), .acc_o(bacc_n[b])
			);
		end else begin : g_hold
			assign brem_n[b] = brem_in[b];
			assign bacc_n[b] = bacc_in[b];
		end
	end

	// Valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (en) begin
			den_q  <= den_in;
			rem_q  <= rem_n;
			acc_q  <= acc_n;
			bden_q <= bden_in;
			brem_q <= brem_n;
			bacc_q <= bacc_n;
			side_q <= side_in;
		end
	end
endmodule

// ===== sv/octahedral_cell_key_encoder.sv =====
// Octahedral cell key encoder: top level with front end, divider chain, output.
// Depends on oce_pkg, oce_if, oce_cell and oce_div_step.
//
// Usage:
//   src carries one surface point per transaction (position, normal, level);
//   dst returns one key per transaction in the same order (cell indices,
//   packed octahedral bins, level). cfg writes cell_size; it is always ready
//   and must be written only while the block is empty.
// Pipeline: the src edge loads the first of two front-end stages (squares and
//   abs, then fold and bin dividend); then a chain of 32 cells that each retire
//   one quotient bit of every position divide, the leading cells, one per bin
//   quotient bit, also one of each bin divide; then one output stage for floor
//   correction and packing.
// Throughput: one transaction per cycle while dst.ready stays high; the 32-cell
//   restoring divider chain is fully pipelined.
// Reset: arst_n clears every valid bit and sets cell_size to 1.0; src.ready
//   is high from release on, so the first edge after release can accept.
// Stall: when dst.ready is low, the output holds and items close up behind
//   it; src.ready drops only when every stage is full.
module octahedral_cell_key_encoder #(
	parameter int MAX_LEVEL_SHIFT = 20
) (
	input  logic      clk,
	input  logic      arst_n,
	oce_in_if.sink    src,
	oce_out_if.source dst,
	oce_cfg_if.sink   cfg
);
	import oce_pkg::*;

	localparam int DW = POS_W + MAX_LEVEL_SHIFT;
	localparam int NC = POS_W;
	localparam logic [LVL_W-1:0] SHIFT_CAP = LVL_W'(MAX_LEVEL_SHIFT);

	// Configuration register
	logic [CFG_W-1:0] cell_size_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q <= CELL_SIZE_RST;
		end else if (cfg.valid) begin
			cell_size_q <= cfg.cell_size;
		end
	end

	// ---------------- Stage 1: magnitudes, divisor, squares ----------------
	logic                            v_s1, en_s1, en_s2, en_post;
	logic [NUM_AXES-1:0][POS_W-1:0]  pmag_s1;
	oce_side_t                       side_s1;
	logic [DW-1:0]                   den_s1;
	logic [NUM_AXES-1:0][30:0]       sq_s1;
	logic [NUM_AXES-1:0][NRM_W-1:0]  nabs_s1;
	logic [NUM_AXES-1:0]             nneg_s1;

	logic [NUM_AXES-1:0][POS_W-1:0]  pos_w;
	logic [NUM_AXES-1:0][NRM_W-1:0]  nrm_w;
	logic signed [NUM_AXES-1:0][2*NRM_W-1:0] sq_w;
	logic [LVL_W-1:0]                shift_w;

	assign pos_w   = {src.pos_z, src.pos_y, src.pos_x};
	assign nrm_w   = {src.normal_z, src.normal_y, src.normal_x};
	assign shift_w = (src.level < SHIFT_CAP) ? src.level : SHIFT_CAP;

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_sq
		assign sq_w[a] = $signed(nrm_w[a]) * $signed(nrm_w[a]);
	end

	assign src.ready = en_s1;
	assign en_s1     = !v_s1 || en_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= src.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				pmag_s1[a]     <= pos_w[a][POS_W-1] ? (~pos_w[a] + 1'b1) : pos_w[a];
				side_s1.neg[a] <= pos_w[a][POS_W-1];
				sq_s1[a]       <= sq_w[a][30:0];
				nabs_s1[a]     <= nrm_w[a][NRM_W-1] ? (~nrm_w[a] + 1'b1) : nrm_w[a];
				nneg_s1[a]     <= nrm_w[a][NRM_W-1];
			end
			side_s1.zero  <= (cell_size_q == '0);
			side_s1.level <= src.level;
			den_s1        <= DW'(cell_size_q) << shift_w;
		end
	end

	// ---------------- Stage 2: short test, fold, bin dividends ----------------
	logic                                 v_s2;
	logic [NUM_AXES-1:0][POS_W-1:0]       pmag_s2;
	oce_side_t                            side_s2;
	logic [DW-1:0]                        den_s2;
	logic [BIN_RW-1:0]                    bden_s2;
	logic [NUM_BIN_LANES-1:0][BIN_RW-1:0] brem_s2;
	logic [NUM_BIN_LANES-1:0][BIN_QW-1:0] bacc_s2;

	logic [31:0]                          sq_sum;
	logic                                 is_short;
	logic [NUM_AXES-1:0][BIN_RW-1:0]      am;
	logic [NUM_AXES-1:0]                  an;
	logic [BIN_RW-1:0]                    l1;
	logic [NUM_BIN_LANES-1:0][BIN_RW-1:0] fmag, shifted;
	logic [NUM_BIN_LANES-1:0][BIN_DVD_W-1:0] dvd;

	// Replace a short normal by (0,1,0)
	always_comb begin
		sq_sum   = 32'(sq_s1[0]) + 32'(sq_s1[1]) + 32'(sq_s1[2]);
		is_short = sq_sum <= SHORT_LIMIT;
		for (int a = 0; a < NUM_AXES; a++) begin
			am[a] = is_short ? '0 : BIN_RW'(nabs_s1[a]);
			an[a] = is_short ? 1'b0 : nneg_s1[a];
		end
		if (is_short) begin
			am[1] = BIN_RW'(1);
		end
		l1 = am[0] + am[1] + am[2];
	end

	// Fold into the upper hemisphere, then dividend = (o*L1 + L1)*255
	for (genvar b = 0; b < NUM_BIN_LANES; b++) begin : g_fold
		assign fmag[b]    = an[2] ? (l1 - am[1-b]) : am[b];
		assign shifted[b] = an[b] ? (l1 - fmag[b]) : (l1 + fmag[b]);
		assign dvd[b]     = (BIN_DVD_W'(shifted[b]) << BIN_QW) - BIN_DVD_W'(shifted[b]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			pmag_s2 <= pmag_s1;
			side_s2 <= side_s1;
			den_s2  <= den_s1;
			bden_s2 <= l1 << 1;
			for (int b = 0; b < NUM_BIN_LANES; b++) begin
				brem_s2[b] <= dvd[b][BIN_DVD_W-1:BIN_QW];
				bacc_s2[b] <= dvd[b][BIN_QW-1:0];
			end
		end
	end

	// ---------------- Divider chain ----------------
	logic [NC:0]                                 c_v, c_en;
	logic [NC:0][DW-1:0]                         c_den;
	logic [NC:0][NUM_AXES-1:0][DW-1:0]           c_rem;
	logic [NC:0][NUM_AXES-1:0][POS_W-1:0]        c_acc;
	logic [NC:0][BIN_RW-1:0]                     c_bden;
	logic [NC:0][NUM_BIN_LANES-1:0][BIN_RW-1:0]  c_brem;
	logic [NC:0][NUM_BIN_LANES-1:0][BIN_QW-1:0]  c_bacc;
	oce_side_t [NC:0]                            c_side;

	assign c_v[0]    = v_s2;
	assign c_den[0]  = den_s2;
	assign c_rem[0]  = '0;
	assign c_acc[0]  = pmag_s2;
	assign c_bden[0] = bden_s2;
	assign c_brem[0] = brem_s2;
	assign c_bacc[0] = bacc_s2;
	assign c_side[0] = side_s2;
	assign en_s2     = !v_s2 || c_en[0];
	assign c_en[NC]  = en_post;

	for (genvar k = 0; k < NC; k++) begin : g_cell
		oce_cell #(.DW(DW), .DO_BIN(k < BIN_QW)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.en_next(c_en[k+1]), .en(c_en[k]),
			.v_in(c_v[k]), .v_q(c_v[k+1]),
			.den_in(c_den[k]), .rem_in(c_rem[k]), .acc_in(c_acc[k]),
			.bden_in(c_bden[k]), .brem_in(c_brem[k]), .bacc_in(c_bacc[k]),
			.side_in(c_side[k]),
			.den_q(c_den[k+1]), .rem_q(c_rem[k+1]), .acc_q(c_acc[k+1]),
			.bden_q(c_bden[k+1]), .brem_q(c_brem[k+1]), .bacc_q(c_bacc[k+1]),
			.side_q(c_side[k+1])
		);
	end

	// ---------------- Output stage: floor for negatives, pack ----------------
	logic                           out_v_q;
	logic [NUM_AXES-1:0][POS_W-1:0] cell_q;
	logic [CODE_W-1:0]              code_q;
	logic [LVL_W-1:0]               level_q;
	logic [NUM_AXES-1:0][POS_W-1:0] cell_w;
	oce_side_t                      side_e;

	assign side_e  = c_side[NC];
	assign en_post = !out_v_q || dst.ready;

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_floor
		logic [POS_W-1:0] qup;
		assign qup       = c_acc[NC][a] + POS_W'(|c_rem[NC][a]);
		assign cell_w[a] = side_e.zero ? '0 :
			(side_e.neg[a] ? (~qup + 1'b1) : c_acc[NC][a]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en_post) begin
			out_v_q <= c_v[NC];
		end
	end

	always_ff @(posedge clk) begin
		if (en_post) begin
			cell_q  <= cell_w;
			code_q  <= side_e.zero ? '0 : {c_bacc[NC][0], c_bacc[NC][1]};
			level_q <= side_e.level;
		end
	end

	assign dst.valid       = out_v_q;
	assign dst.cell_x      = cell_q[0];
	assign dst.cell_y      = cell_q[1];
	assign dst.cell_z      = cell_q[2];
	assign dst.normal_code = code_q;
	assign dst.level_out   = level_q;
endmodule

// ===== sv/oce_checker.sv =====
// Port-level checks for the octahedral cell key encoder, bound to the top level.
// Depends only on the top level's ports.
module oce_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        src_valid,
	input logic        src_ready,
	input logic        dst_valid,
	input logic        dst_ready,
	input logic [31:0] dst_cell_x,
	input logic [15:0] dst_code,
	input logic        cfg_ready
);
	// Hold a stalled result
	a_dst_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_ready |=> dst_valid && $stable(dst_cell_x) && $stable(dst_code))
		else $error("stalled result changed");

	// Accept whenever the output is empty
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!dst_valid |-> src_ready)
		else $error("input stalled with empty output");

	// Output empty right after reset release
	a_rst_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !dst_valid)
		else $error("result present after reset");

	// Configuration always taken
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

	// Back-pressure on the input only when the output is stalled
	a_src_stall: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && !src_ready |-> dst_valid && !dst_ready)
		else $error("input stalled while output moves");
endmodule

bind octahedral_cell_key_encoder oce_checker u_oce_checker (
	.clk(clk),
	.arst_n(arst_n),
	.src_valid(src.valid),
	.src_ready(src.ready),
	.dst_valid(dst.valid),
	.dst_ready(dst.ready),
	.dst_cell_x(dst.cell_x),
	.dst_code(dst.normal_code),
	.cfg_ready(cfg.ready)
);

// ===== tb/octahedral_cell_key_encoder_test.sv =====
// Testbench for the octahedral cell key encoder: directed and random points under
// several cell sizes, with sender and receiver idling. Depends on oce_pkg, oce_if and the top level.
module octahedral_cell_key_encoder_test;
	timeunit 1ns;
	timeprecision 1ps;
	import oce_pkg::*;

	typedef struct packed {
		logic signed [POS_W-1:0] px, py, pz;
		logic signed [NRM_W-1:0] nx, ny, nz;
		logic [LVL_W-1:0]        lvl;
	} point_t;

	typedef struct packed {
		logic signed [POS_W-1:0] cx, cy, cz;
		logic [CODE_W-1:0]       code;
		logic [LVL_W-1:0]        lvl;
	} key_t;

	localparam int MAX_SHIFT = 20;

	logic clk = 0;
	logic arst_n = 0;
	oce_in_if  src();
	oce_out_if dst();
	oce_cfg_if cfg();

	octahedral_cell_key_encoder #(.MAX_LEVEL_SHIFT(MAX_SHIFT)) dut (
		.clk(clk), .arst_n(arst_n), .src(src), .dst(dst), .cfg(cfg)
	);

	key_t        pending_keys[$];
	logic [31:0] cell_edge = CELL_SIZE_RST;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          errors = 0;

	initial forever #5 clk = ~clk;

	// Floor divide a position by the scaled edge, clamped to 32 bits
	function automatic logic signed [31:0] cell_of(logic signed [31:0] p, longint div);
		longint q;
		longint a;
		a = p;
		if (a >= 0) q = a / div;
		else q = -((-a + div - 1) / div);
		if (q > 64'sd2147483647) q = 64'sd2147483647;
		if (q < -64'sd2147483648) q = -64'sd2147483648;
		return q[31:0];
	endfunction

	function automatic logic [7:0] bin_of(longint num, longint den);
		longint s;
		longint b;
		s = num + den;
		if (s < 0) s = 0;
		b = (s * 255) / (2 * den);
		return (b > 255) ? 8'd255 : b[7:0];
	endfunction

	function automatic key_t encode_key(point_t p);
		key_t k;
		longint div, x, y, z, ax, ay, l1, ox, oy;
		k.lvl = p.lvl;
		if (cell_edge == 0) begin
			k.cx = '0; k.cy = '0; k.cz = '0; k.code = '0;
			return k;
		end
		div = longint'(cell_edge) << ((p.lvl < MAX_SHIFT) ? p.lvl : MAX_SHIFT);
		k.cx = cell_of(p.px, div);
		k.cy = cell_of(p.py, div);
		k.cz = cell_of(p.pz, div);
		x = p.nx; y = p.ny; z = p.nz;
		// Replace a short normal by straight up
		if (x * x + y * y + z * z <= longint'(SHORT_LIMIT)) begin
			x = 0; y = 1; z = 0;
		end
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		l1 = ax + ay + ((z < 0) ? -z : z);
		if (z < 0) begin
			ox = (x < 0) ? -(l1 - ay) : (l1 - ay);
			oy = (y < 0) ? -(l1 - ax) : (l1 - ax);
		end else begin
			ox = x; oy = y;
		end
		k.code = {bin_of(ox, l1), bin_of(oy, l1)};
		return k;
	endfunction

	// Receiver: random stall, check each transaction against the oldest key
	initial begin
		dst.ready = 0;
		forever begin
			@(negedge clk);
			dst.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		key_t got, want;
		if (arst_n && dst.valid && dst.ready) begin
			got = {dst.cell_x, dst.cell_y, dst.cell_z, dst.normal_code, dst.level_out};
			if (pending_keys.size() == 0) begin
				$display("%0t: unexpected key %h", $realtime, got);
				errors++;
			end else begin
				want = pending_keys.pop_front();
				if (got.cx !== want.cx)
					$display("%0t: cell_x exp %0d got %0d", $realtime, want.cx, got.cx);
				if (got.cy !== want.cy)
					$display("%0t: cell_y exp %0d got %0d", $realtime, want.cy, got.cy);
				if (got.cz !== want.cz)
					$display("%0t: cell_z exp %0d got %0d", $realtime, want.cz, got.cz);
				if (got.code !== want.code)
					$display("%0t: normal_code exp %h got %h", $realtime, want.code, got.code);
				if (got.lvl !== want.lvl)
					$display("%0t: level_out exp %0d got %0d", $realtime, want.lvl,
						got.lvl);
				if (got !== want) errors++;
			end
		end
	end

	// Send one point, idling first at random; valid stays high after the transaction
	task automatic send_point(point_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			src.valid <= 0;
			@(negedge clk);
		end
		{src.pos_x, src.pos_y, src.pos_z, src.normal_x, src.normal_y, src.normal_z,
			src.level} <= p;
		src.valid <= 1;
		do @(posedge clk); while (!src.ready);
		pending_keys.insert(pending_keys.size(), encode_key(p));
		@(negedge clk);
	endtask

	// Drop valid and wait until every key has come back
	task automatic drain();
		src.valid <= 0;
		while (pending_keys.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	// Write the cell edge while the block is empty
	task automatic write_cell_edge(logic [31:0] v);
		drain();
		cfg.cell_size <= v;
		cfg.valid <= 1;
		do @(posedge clk); while (!cfg.ready);
		cell_edge = v;
		@(negedge clk);
		cfg.valid <= 0;
	endtask

	function automatic logic [31:0] rand_pos();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(4) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
			2: return $signed($urandom_range(2000)) - 1000;
			default: return {{16{1'($urandom_range(1))}}, 16'($urandom)};
		endcase
	endfunction

	function automatic logic [15:0] rand_normal();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(80)) - 40);
			2: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
			default: return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
		endcase
	endfunction

	function automatic point_t rand_point();
		point_t p;
		p.px = rand_pos(); p.py = rand_pos(); p.pz = rand_pos();
		p.nx = rand_normal(); p.ny = rand_normal(); p.nz = rand_normal();
		p.lvl = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(22));
		return p;
	endfunction

	// Directed corners: position extremes, levels, short normals, folds, then random points
	task automatic test_directed();
		point_t p;
		send_point({32'h7fff_ffff, 32'h8000_0000, 32'h0, 16'sd16384, 16'sd0, 16'sd0, 8'd0});
		send_point({32'h8000_0000, 32'h7fff_ffff, -32'sd1, 16'h8000, 16'h8000, 16'h8000,
			8'd255});
		send_point({32'h0001_0000, -32'sh0001_0000, 32'h0, 16'sd0, 16'sd0, 16'sd0, 8'd20});
		send_point({-32'sd1, 32'sd1, 32'sd65535, 16'sd30, 16'sd30, 16'sd29, 8'd19});
		send_point({32'h1234_5678, 32'h0, 32'h0, 16'sd31, 16'sd30, 16'sd30, 8'd21});
		send_point({32'h0, 32'h0, 32'h0, 16'sd0, 16'sd0, -16'sd16384, 8'd1});
		send_point({32'h0, 32'h0, 32'h0, -16'sd100, 16'sd200, -16'sd300, 8'd2});
		send_point({32'h0, 32'h0, 32'h0, 16'sd100, -16'sd200, -16'sd300, 8'd3});
		send_point({32'h0, 32'h0, 32'h0, 16'h7fff, 16'h7fff, 16'h7fff, 8'd128});
		send_point({32'h0, 32'h0, 32'h0, 16'sd0, -16'sd16384, 16'sd0, 8'd4});
		send_point({32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff,
			16'hffff, 8'hff});
		repeat (8) begin
			p = rand_point();
			send_point(p);
		end
	endtask

	task automatic test_random(int n);
		repeat (n) send_point(rand_point());
	endtask

	// Sweep cell edges, extremes and zero included
	task automatic test_cell_edges();
		write_cell_edge(32'd1);
		test_random(40);
		write_cell_edge(32'hffff_ffff);
		test_random(40);
		write_cell_edge(32'd0);
		test_random(20);
		write_cell_edge(32'd3);
		test_random(40);
		write_cell_edge($urandom);
		test_random(40);
		write_cell_edge(CELL_SIZE_RST);
	endtask

	initial begin
		src.valid = 0;
		{src.pos_x, src.pos_y, src.pos_z, src.normal_x, src.normal_y, src.normal_z,
			src.level} = '0;
		cfg.valid = 0;
		cfg.cell_size = '0;
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		send_idle_pct = 33; recv_idle_pct = 68;
		test_directed();
		test_random(180);
		send_idle_pct = 68; recv_idle_pct = 33;
		test_cell_edges();
		test_random(150);
		send_idle_pct = 0; recv_idle_pct = 0;
		write_cell_edge(32'd5);
		test_random(170);
		drain();
		if (errors == 0)
			$display("octahedral_cell_key_encoder_test: clean");
		else
			$display("octahedral_cell_key_encoder_test: errors");
		$finish;
	end

	// Timeout guard
	initial begin
		#2ms;
		$display("octahedral_cell_key_encoder_test: errors");
		$finish;
	end

endmodule
